// File: hw/rtl/drrm_pkg.sv
// shared constants, types and helpers for the decay pulse rng and rate meter
// no dependencies
`timescale 1ns / 1ps

package drrm_pkg;

  localparam int CountWidth    = 16;
  localparam int TimerWidth    = 24;
  localparam int CpmWidth      = 24;
  localparam int SlotsWidth    = 8;
  localparam int DigitWidth    = 4;
  localparam int LevelWidth    = 3;
  localparam int MaskWidth     = 5;
  localparam int NumThresholds = 5;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 24;

  localparam int ProdWidth   = CountWidth + SlotsWidth;
  localparam int ProdExtWidth = (ProdWidth > CpmWidth) ? ProdWidth : CpmWidth;

  localparam logic [TimerWidth-1:0] TimerMax = {TimerWidth{1'b1}};
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
  localparam logic [CpmWidth-1:0]   CpmMax   = {CpmWidth{1'b1}};

  localparam logic [TimerWidth-1:0] PrintPeriodReset = TimerWidth'(1000);
  localparam logic [TimerWidth-1:0] PollPeriodReset  = TimerWidth'(20000);
  localparam logic [SlotsWidth-1:0] SlotsReset       = SlotsWidth'(3);
  localparam logic [NumThresholds-1:0][CpmWidth-1:0] ThresholdReset = {
    CpmWidth'(800), CpmWidth'(400), CpmWidth'(200), CpmWidth'(100), CpmWidth'(50)
  };

  localparam logic [LevelWidth-1:0] LevelTop = LevelWidth'(NumThresholds);

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_PRINT_PERIOD = 3'd0,
    REG_POLL_PERIOD  = 3'd1,
    REG_WINDOW_SLOTS = 3'd2,
    REG_THRESHOLD_1  = 3'd3,
    REG_THRESHOLD_2  = 3'd4,
    REG_THRESHOLD_3  = 3'd5,
    REG_THRESHOLD_4  = 3'd6,
    REG_THRESHOLD_5  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [TimerWidth-1:0]                    print_period;
    logic [TimerWidth-1:0]                    poll_period;
    logic [SlotsWidth-1:0]                    slots;
    logic [NumThresholds-1:0][CpmWidth-1:0]   thr;
  } cfg_t;

  typedef struct packed {
    logic                    digit_valid;
    logic [DigitWidth-1:0]   digit;
    logic                    rate_valid;
    logic [ProdExtWidth-1:0] prod;
  } step_res_t;

  function automatic logic [MaskWidth-1:0] led_mask_of(input logic [LevelWidth-1:0] lvl);
    logic [MaskWidth:0] ones;
    ones = ((MaskWidth+1)'(1) << lvl) - (MaskWidth+1)'(1);
    return ones[MaskWidth-1:0];
  endfunction

endpackage

// File: hw/rtl/drrm_in_if.sv
// input channel: one time step per transaction
// no dependencies
`timescale 1ns / 1ps

interface drrm_in_if;
  logic valid;
  logic ready;
  logic pulse;
  logic ms_tick;

  modport source (output valid, output pulse, output ms_tick, input ready);
  modport sink   (input valid, input pulse, input ms_tick, output ready);
  modport mon    (input valid, input pulse, input ms_tick, input ready);
endinterface

// File: hw/rtl/drrm_out_if.sv
// result channel: digit and rate fields per transaction
// depends on drrm_pkg
`timescale 1ns / 1ps

interface drrm_out_if;
  import drrm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  digit_valid;
  logic [DigitWidth-1:0] digit;
  logic                  rate_valid;
  logic [CpmWidth-1:0]   counts_per_minute;
  logic [LevelWidth-1:0] bar_level;
  logic [MaskWidth-1:0]  led_mask;

  modport source (output valid, output digit_valid, output digit, output rate_valid,
                  output counts_per_minute, output bar_level, output led_mask,
                  input ready);
  modport sink   (input valid, input digit_valid, input digit, input rate_valid,
                  input counts_per_minute, input bar_level, input led_mask,
                  output ready);
  modport mon    (input valid, input digit_valid, input digit, input rate_valid,
                  input counts_per_minute, input bar_level, input led_mask,
                  input ready);
endinterface

// File: hw/rtl/drrm_cfg_if.sv
// configuration write channel: register index and data per transaction
// depends on drrm_pkg
`timescale 1ns / 1ps

interface drrm_cfg_if;
  import drrm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  logic [CfgDataWidth-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
  modport mon    (input valid, input index, input data, input ready);
endinterface

// File: hw/rtl/drrm_cfg_regs.sv
// configuration register file, written through the config channel
// depends on drrm_pkg, drrm_cfg_if
`timescale 1ns / 1ps

module drrm_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  drrm_cfg_if.sink      cfg,
  output drrm_pkg::cfg_t regs
);
  import drrm_pkg::*;

  cfg_reg_t idx;

  assign cfg.ready = 1'b1;
  assign idx = cfg_reg_t'(cfg.index);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.print_period <= PrintPeriodReset;
      regs.poll_period  <= PollPeriodReset;
      regs.slots        <= SlotsReset;
      regs.thr          <= ThresholdReset;
    end else if (cfg.valid) begin
      case (idx)
        REG_PRINT_PERIOD: regs.print_period <= cfg.data[TimerWidth-1:0];
        REG_POLL_PERIOD:  regs.poll_period  <= cfg.data[TimerWidth-1:0];
        REG_WINDOW_SLOTS: regs.slots        <= cfg.data[SlotsWidth-1:0];
        REG_THRESHOLD_1:  regs.thr[0]       <= cfg.data[CpmWidth-1:0];
        REG_THRESHOLD_2:  regs.thr[1]       <= cfg.data[CpmWidth-1:0];
        REG_THRESHOLD_3:  regs.thr[2]       <= cfg.data[CpmWidth-1:0];
        REG_THRESHOLD_4:  regs.thr[3]       <= cfg.data[CpmWidth-1:0];
        REG_THRESHOLD_5:  regs.thr[4]       <= cfg.data[CpmWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/drrm_step_stage.sv
// per-step state: roulette counter, digit latch, pulse count, timers, window product
// depends on drrm_pkg, drrm_in_if
`timescale 1ns / 1ps

module drrm_step_stage (
  input  logic               clk,
  input  logic               rst,
  drrm_in_if.sink            step,
  input  drrm_pkg::cfg_t     cfg,
  output logic               res_valid,
  output drrm_pkg::step_res_t res,
  input  logic               res_ready
);
  import drrm_pkg::*;

  logic [DigitWidth-1:0] roulette;
  logic [DigitWidth-1:0] latched_digit;
  logic                  digit_seen;
  logic                  digit_fresh;
  logic [CountWidth-1:0] pulse_counter;
  logic [TimerWidth-1:0] print_timer;
  logic [TimerWidth-1:0] poll_timer;

  logic [DigitWidth-1:0] latched_digit_next;
  logic                  digit_seen_next;
  logic                  digit_fresh_next;
  logic [CountWidth-1:0] pulse_counter_next;
  logic [TimerWidth-1:0] print_timer_next;
  logic [TimerWidth-1:0] poll_timer_next;
  logic [CountWidth-1:0] count_upd;
  logic [TimerWidth-1:0] print_upd;
  logic [TimerWidth-1:0] poll_upd;
  logic                  print_fire;
  logic                  poll_fire;
  logic                  accept;
  step_res_t             res_next;

  assign step.ready = !res_valid || res_ready;
  assign accept     = step.valid && step.ready;

  always_comb begin
    latched_digit_next = latched_digit;
    digit_seen_next    = digit_seen;
    digit_fresh_next   = digit_fresh;
    count_upd          = pulse_counter;
    if (step.pulse) begin
      latched_digit_next = roulette;
      digit_seen_next    = 1'b1;
      digit_fresh_next   = 1'b1;
      if (pulse_counter != CountMax) begin
        count_upd = pulse_counter + CountWidth'(1);
      end
    end

    print_upd = (step.ms_tick && print_timer != TimerMax) ? print_timer + TimerWidth'(1)
                                                          : print_timer;
    poll_upd  = (step.ms_tick && poll_timer != TimerMax) ? poll_timer + TimerWidth'(1)
                                                         : poll_timer;
    print_fire = print_upd > cfg.print_period;
    poll_fire  = poll_upd > cfg.poll_period;

    res_next.digit_valid = print_fire && digit_fresh_next && digit_seen_next;
    res_next.digit       = res_next.digit_valid ? latched_digit_next : '0;
    res_next.rate_valid  = poll_fire;
    res_next.prod        = ProdExtWidth'(cfg.slots) * ProdExtWidth'(count_upd);

    print_timer_next = print_fire ? '0 : print_upd;
    if (print_fire) begin
      digit_fresh_next = 1'b0;
    end
    poll_timer_next    = poll_fire ? '0 : poll_upd;
    pulse_counter_next = poll_fire ? '0 : count_upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roulette      <= '0;
      latched_digit <= '0;
      digit_seen    <= 1'b0;
      digit_fresh   <= 1'b0;
      pulse_counter <= '0;
      print_timer   <= '0;
      poll_timer    <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (accept) begin
        roulette      <= roulette + DigitWidth'(1);
        latched_digit <= latched_digit_next;
        digit_seen    <= digit_seen_next;
        digit_fresh   <= digit_fresh_next;
        pulse_counter <= pulse_counter_next;
        print_timer   <= print_timer_next;
        poll_timer    <= poll_timer_next;
        res_valid     <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

endmodule

// File: hw/rtl/drrm_band_stage.sv
// rate saturation, threshold banding with held level, result register
// depends on drrm_pkg, drrm_out_if
`timescale 1ns / 1ps

module drrm_band_stage (
  input  logic                clk,
  input  logic                rst,
  input  drrm_pkg::cfg_t      cfg,
  input  logic                res_valid,
  input  drrm_pkg::step_res_t res,
  output logic                res_ready,
  drrm_out_if.source          result
);
  import drrm_pkg::*;

  logic [LevelWidth-1:0] held_level;
  logic [LevelWidth-1:0] level_next;
  logic [CpmWidth-1:0]   cpm;
  logic                  load;

  assign res_ready = !result.valid || result.ready;
  assign load      = res_valid && res_ready;

  always_comb begin
    cpm = (res.prod > ProdExtWidth'(CpmMax)) ? CpmMax : res.prod[CpmWidth-1:0];
    level_next = held_level;
    if (cpm <= cfg.thr[0]) begin
      level_next = '0;
    end
    for (int i = 1; i < NumThresholds; i++) begin
      if (cpm <= cfg.thr[i] && cpm > cfg.thr[i-1]) begin
        level_next = LevelWidth'(i);
      end
    end
    if (cpm > cfg.thr[NumThresholds-1]) begin
      level_next = LevelTop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_level   <= '0;
      result.valid <= 1'b0;
    end else begin
      if (load) begin
        result.valid <= 1'b1;
        if (res.rate_valid) begin
          held_level <= level_next;
        end
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.digit_valid       <= res.digit_valid;
      result.digit             <= res.digit;
      result.rate_valid        <= res.rate_valid;
      result.counts_per_minute <= res.rate_valid ? cpm : '0;
      result.bar_level         <= res.rate_valid ? level_next : '0;
      result.led_mask          <= res.rate_valid ? led_mask_of(level_next) : '0;
    end
  end

endmodule

// File: hw/rtl/decay_pulse_rng_and_rate_meter_top.sv
// top level of the decay pulse random digit generator and rate meter
// depends on drrm_pkg, the channel interfaces, drrm_cfg_regs, drrm_step_stage, drrm_band_stage
`timescale 1ns / 1ps

// Each time step that is taken gives exactly one result, registered by the first stage
// and again by the second. The first stage updates the roulette counter, the digit
// latch, the saturating pulse count and both millisecond timers, and forms window_slots
// times the count in a single multiplier; the second stage saturates that product to
// 24 bits, picks the bar level against the five thresholds and holds the result until
// it is taken. The second stage stalls when the result is not taken, the first once
// its own result is held too, so throughput is one step per cycle while result.ready
// stays high. Configuration writes are always accepted; the thresholds are read by the
// second stage when it loads a step's result, so write only while no step is in flight.

module decay_pulse_rng_and_rate_meter_top (
  input  logic        clk,
  input  logic        rst,
  drrm_in_if.sink     step,
  drrm_out_if.source  result,
  drrm_cfg_if.sink    cfg
);
  import drrm_pkg::*;

  cfg_t      regs;
  logic      res_valid;
  logic      res_ready;
  step_res_t res;

  drrm_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  drrm_step_stage u_step (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .cfg       (regs),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  drrm_band_stage u_band (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .result    (result)
  );

endmodule

// File: hw/rtl/drrm_checker.sv
// port-level checks on the result channel of the top level, bound in below
// depends on drrm_pkg and the top level
`timescale 1ns / 1ps

module drrm_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             valid,
  input logic                             ready,
  input logic                             digit_valid,
  input logic [drrm_pkg::DigitWidth-1:0]  digit,
  input logic                             rate_valid,
  input logic [drrm_pkg::CpmWidth-1:0]    counts_per_minute,
  input logic [drrm_pkg::LevelWidth-1:0]  bar_level,
  input logic [drrm_pkg::MaskWidth-1:0]   led_mask
);
  import drrm_pkg::*;

  a_digit_zero: assert property (@(posedge clk) disable iff (rst)
    valid && !digit_valid |-> digit == '0)
    else $error("digit nonzero without digit_valid");

  a_rate_zero: assert property (@(posedge clk) disable iff (rst)
    valid && !rate_valid |->
      counts_per_minute == '0 && bar_level == '0 && led_mask == '0)
    else $error("rate fields nonzero without rate_valid");

  a_mask_level: assert property (@(posedge clk) disable iff (rst)
    valid && rate_valid |->
      bar_level <= LevelTop && led_mask == led_mask_of(bar_level))
    else $error("led_mask does not match bar_level");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(digit_valid)
      && $stable(digit) && $stable(rate_valid)
      && $stable(counts_per_minute) && $stable(bar_level))
    else $error("result changed while stalled");

endmodule

bind decay_pulse_rng_and_rate_meter_top drrm_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .valid             (result.valid),
  .ready             (result.ready),
  .digit_valid       (result.digit_valid),
  .digit             (result.digit),
  .rate_valid        (result.rate_valid),
  .counts_per_minute (result.counts_per_minute),
  .bar_level         (result.bar_level),
  .led_mask          (result.led_mask)
);
